[design/linear_probe_snapshot_table_macros.svh]
// Assertion macros for the linear probe snapshot table.
// Included by modules that carry concurrent checks.
`ifndef LINEAR_PROBE_SNAPSHOT_TABLE_MACROS_SVH
`define LINEAR_PROBE_SNAPSHOT_TABLE_MACROS_SVH
`define LPST_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPST_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/lpst_pkg.sv]
// Shared types and constants for the linear probe snapshot table.
// No dependencies.
package lpst_pkg;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_PROBES = 16;
  localparam int KEY_W = 64;
  localparam int CFG_W = 11;
  localparam int SLOT_W = 10;
  localparam logic CFG_ENTRIES = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  typedef enum logic {ACT_LOOKUP = 1'b0, ACT_UPDATE = 1'b1} act_t;

  typedef struct packed {
    act_t             act;
    logic             en;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] pay;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] pay;
    logic [SLOT_W-1:0] slot;
    logic             evict;
  } res_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_MOD, BK_READ, BK_WAIT, BK_CHECK, BK_DONE
  } bk_state_t;
endpackage

[design/lpst_front.sv]
// Front end: accepts input words, samples config, pushes commands to queue.
// Depends on lpst_pkg.
module lpst_front (
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tuser,
  input  logic [127:0] s_tdata,
  input  logic en,
  input  logic q_full,
  output logic q_push,
  output lpst_pkg::cmd_t q_data
);
  import lpst_pkg::*;
  assign s_tready = !q_full;
  assign q_push = s_tvalid && !q_full;
  always_comb begin
    q_data.act = act_t'(s_tuser);
    q_data.en = en;
    q_data.key = s_tdata[63:0];
    q_data.pay = s_tdata[127:64];
  end
endmodule

[design/lpst_queue.sv]
// Two-entry command queue between front and back ends.
// Depends on lpst_pkg.
module lpst_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lpst_pkg::cmd_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output lpst_pkg::cmd_t dout
);
  import lpst_pkg::*;
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign dout = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[design/lpst_back.sv]
// Back end: home-slot modulo, probe sequencer, slot memory, result register.
// Depends on lpst_pkg and the macros header.
`include "linear_probe_snapshot_table_macros.svh"
module lpst_back #(
  parameter int TABLE_DEPTH = lpst_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBES = lpst_pkg::DEF_MAX_PROBES
) (
  input  logic clk,
  input  logic rst,
  input  logic [lpst_pkg::CFG_W-1:0] entries,
  input  logic q_empty,
  input  lpst_pkg::cmd_t q_data,
  output logic q_pop,
  output logic m_tvalid,
  input  logic m_tready,
  output lpst_pkg::res_t m_res
);
  import lpst_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int NW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  bk_state_t state, state_next;
  cmd_t cmd;
  res_t acc;
  logic [NW-1:0] n;
  logic [NW-1:0] rem;
  logic [6:0] bitc;
  logic [5:0] bidx;
  logic [AW-1:0] home, slot, clr;
  logic [PW-1:0] probe;
  logic [KEY_W-1:0] keys [TABLE_DEPTH];
  logic [KEY_W-1:0] pays [TABLE_DEPTH];
  logic [KEY_W-1:0] rkey, rpay;
  logic match, empty_s, wr;
  logic [AW-1:0] waddr;
  logic [NW:0] rem_sh;
  logic [NW-1:0] ext_cfg;
  logic [NW-1:0] slot_inc;

  assign ext_cfg = NW'(entries);
  assign match = rkey == cmd.key;
  assign empty_s = rkey == '0;
  assign bidx = 6'(bitc - 7'd1);
  assign rem_sh = {rem, cmd.key[bidx]};
  assign slot_inc = NW'({1'b0, slot}) + NW'(1);

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr == AW'(TABLE_DEPTH - 1)) state_next = BK_IDLE;
      BK_IDLE: if (!q_empty) state_next = BK_MOD;
      BK_MOD: begin
        if (!cmd.en) state_next = BK_DONE;
        else if (bitc == 7'd0) state_next = BK_READ;
      end
      BK_READ: state_next = BK_WAIT;
      BK_WAIT: state_next = BK_CHECK;
      BK_CHECK: begin
        if (match || empty_s || probe == PW'(MAX_PROBES - 1)) state_next = BK_DONE;
        else state_next = BK_READ;
      end
      BK_DONE: if (m_tready || !m_tvalid) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = state == BK_IDLE && !q_empty;
    wr = 1'b0;
    waddr = slot;
    if (state == BK_CLEAR) begin
      wr = 1'b1;
      waddr = clr;
    end else if (state == BK_CHECK && cmd.act == ACT_UPDATE) begin
      if (match || empty_s) wr = 1'b1;
      else if (probe == PW'(MAX_PROBES - 1)) begin
        wr = 1'b1;
        waddr = home;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      rkey <= keys[slot];
      rpay <= pays[slot];
    end
    if (wr) begin
      keys[waddr] <= (state == BK_CLEAR) ? '0 : cmd.key;
      pays[waddr] <= (state == BK_CLEAR) ? '0 : cmd.pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr <= clr + AW'(1);
      if (state == BK_DONE && (m_tready || !m_tvalid)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        cmd <= q_data;
        rem <= '0;
        bitc <= 7'd64;
        probe <= '0;
        acc <= '0;
        if (ext_cfg == '0) n <= NW'(1);
        else if (ext_cfg > NW'(TABLE_DEPTH)) n <= NW'(TABLE_DEPTH);
        else n <= ext_cfg;
      end
      BK_MOD: begin
        if (bitc != 7'd0) begin
          bitc <= bitc - 7'd1;
          if (rem_sh >= {1'b0, n}) rem <= NW'(rem_sh - {1'b0, n});
          else rem <= rem_sh[NW-1:0];
        end else begin
          home <= rem[AW-1:0];
          slot <= rem[AW-1:0];
        end
      end
      BK_CHECK: begin
        probe <= probe + PW'(1);
        slot <= (slot_inc == n) ? '0 : slot_inc[AW-1:0];
        if (match || empty_s) begin
          if (cmd.act == ACT_UPDATE || match) begin
            acc.hit <= 1'b1;
            acc.slot <= SLOT_W'(slot);
            acc.pay <= cmd.act == ACT_LOOKUP ? rpay : '0;
          end
        end else if (probe == PW'(MAX_PROBES - 1) && cmd.act == ACT_UPDATE) begin
          acc.slot <= SLOT_W'(home);
          acc.evict <= 1'b1;
        end
      end
      BK_DONE: begin
        if (m_tready || !m_tvalid) m_res <= acc;
      end
      default: ;
    endcase
  end

  `LPST_ASSERT(a_pop_idle, clk, rst, q_pop |-> state == BK_IDLE, "pop outside idle")
  `LPST_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_res), "result changed")
  `LPST_ASSERT(a_evict, clk, rst, m_tvalid |-> !(m_res.hit && m_res.evict), "hit and evict")
  `LPST_ASSERT_NR(a_rst, clk, rst |=> !m_tvalid, "valid after reset")
endmodule

[design/linear_probe_snapshot_table.sv]
// Top level of the linear probe snapshot table.
// Depends on lpst_pkg, lpst_front, lpst_queue, lpst_back.
// Usage:
//  s_* channel takes one word: tuser = action (0 lookup, 1 update),
//  tdata = record_key then record_payload. m_* channel returns one word per
//  input: tuser = hit then evicted, tdata = payload_out then slot_index.
//  Config: cfg_we with cfg_index 0 entries_in_use, 1 table_enabled; write
//  only while idle.
//  Sequence: an item occupies the back end for a pop, a bit-serial home
//  slot remainder, a read, wait and compare per probe slot for 1 to 16
//  probes, and a step to post the result; when the table is disabled the
//  remainder and probes are skipped. The sequencer in the back end takes
//  one item at a time. A two-word queue lets the input side run ahead of
//  the probe engine. Reset starts a clearing pass that zeroes every slot;
//  input words queue up meanwhile. A stalled receiver holds the result
//  and, once the queue fills, the input side drops tready.
module linear_probe_snapshot_table #(
  parameter int TABLE_DEPTH = lpst_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBES = lpst_pkg::DEF_MAX_PROBES
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tuser,            // action
  input  logic [127:0] s_tdata,    // record_key, record_payload
  output logic m_tvalid,
  input  logic m_tready,
  output logic [1:0] m_tuser,      // hit, evicted
  output logic [79:0] m_tdata,     // payload_out, slot_index, zero fill
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [lpst_pkg::CFG_W-1:0] cfg_data
);
  import lpst_pkg::*;
  logic [CFG_W-1:0] entries;
  logic en;
  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_in, q_out;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= CFG_W'(1024);
      en <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENTRIES) entries <= cfg_data;
      else en <= cfg_data[0];
    end
  end

  lpst_front u_front (.s_tvalid, .s_tready, .s_tuser, .s_tdata, .en,
    .q_full, .q_push, .q_data(q_in));
  lpst_queue u_queue (.clk, .rst, .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_out));
  lpst_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_PROBES(MAX_PROBES)) u_back (
    .clk, .rst, .entries, .q_empty, .q_data(q_out), .q_pop, .m_tvalid, .m_tready,
    .m_res(res));

  assign m_tuser = {res.evict, res.hit};
  assign m_tdata = {6'd0, res.slot, res.pay};
endmodule
